// ===== design/aorf_pkg.sv =====
package aorf_pkg;

	localparam int SAMPLE_W          = 16;
	localparam int CFG_IDX_W         = 2;
	localparam int HISTORY_DEPTH_DEF = 16;
	localparam int WINDOW_STEPS_DEF  = 10;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 2'd2;

	localparam logic MODE_RANGE    = 1'b0;
	localparam logic MODE_ADAPTIVE = 1'b1;

	localparam logic                MODE_RST    = MODE_ADAPTIVE;
	localparam logic [SAMPLE_W-1:0] CEILING_RST = 16'd5000;
	localparam logic [SAMPLE_W-1:0] FLOOR_RST   = 16'd60;

	typedef struct packed {
		logic accept;    // input beat taken this cycle
		logic rd_issue;  // read the history entry at the walk pointer
		logic rd_first;  // this read returns the previous sample
		logic load_out;  // load the result register
	} dp_cmd_t;

	typedef struct packed {
		logic mode;      // current mode register
		logic ready;     // enough history for the deviation window
		logic emit;      // item gives a result
	} dp_sts_t;

endpackage

// ===== design/adaptive_outlier_reject_filter.sv =====
// Outlier-reject filter for 16-bit sensor samples, one sample per input beat and at most one
// result beat. In range mode (mode = 0) a sample at or below floor_level is dropped, a sample
// above zero and below range_ceiling passes, anything else repeats the held value. In
// adaptive mode each sample goes into a HISTORY_DEPTH-entry ring; the first WINDOW_STEPS+1
// samples only fill the ring and give no result. After that the history is walked one
// entry per cycle through the single read port of the ring memory, summing WINDOW_STEPS
// absolute differences ending at the previous sample, and the sample passes if it lies
// within previous +/- sum/(WINDOW_STEPS-1) and above floor_level. A finished result waits in
// an output register while the next sample is taken in. The user must write registers
// only while idle; the block itself does not enforce it.
module adaptive_outlier_reject_filter
	import aorf_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int WINDOW_STEPS  = WINDOW_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SAMPLE_W-1:0]  cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SAMPLE_W-1:0]  sample,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SAMPLE_W-1:0]  filtered_value,
	output logic                 accepted
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	aorf_ctrl #(
		.WINDOW_STEPS(WINDOW_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	aorf_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.WINDOW_STEPS (WINDOW_STEPS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample        (sample),
		.cmd           (cmd),
		.sts           (sts),
		.filtered_value(filtered_value),
		.accepted      (accepted)
	);

endmodule

// ===== design/aorf_ram.sv =====
module aorf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/aorf_dp.sv =====
module aorf_dp
	import aorf_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int WINDOW_STEPS  = WINDOW_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SAMPLE_W-1:0]  cfg_data,
	input  logic [SAMPLE_W-1:0]  sample,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	output logic [SAMPLE_W-1:0]  filtered_value,
	output logic                 accepted
);

	localparam int AW    = $clog2(HISTORY_DEPTH);
	localparam int FW    = $clog2(WINDOW_STEPS + 2);
	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_STEPS);

	logic                mode_q;
	logic [SAMPLE_W-1:0] ceiling_q;
	logic [SAMPLE_W-1:0] floor_q;
	logic [AW-1:0]       wr_q;
	logic [AW-1:0]       rd_addr_q;
	logic [FW-1:0]       fill_q;
	logic [SAMPLE_W-1:0] held_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] prev_q;
	logic [SAMPLE_W-1:0] last_q;
	logic [SUM_W-1:0]    sum_q;
	logic                rd_vld_q;
	logic                rd_first_q;
	logic [SAMPLE_W-1:0] rdata;
	logic                ready;
	logic [SAMPLE_W-1:0] step_diff;
	logic [SAMPLE_W-1:0] dev;
	logic [SUM_W-1:0]    dev_scaled;
	logic                pass;

	function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] a);
		ring_back = (a == '0) ? AW'(HISTORY_DEPTH - 1) : a - AW'(1);
	endfunction

	aorf_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(HISTORY_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (cmd.accept && mode_q),
		.waddr(wr_q),
		.wdata(sample),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	assign ready = (fill_q == FW'(WINDOW_STEPS + 1));

	assign step_diff = (last_q >= rdata) ? last_q - rdata : rdata - last_q;
	assign dev       = (sample_q >= prev_q) ? sample_q - prev_q : prev_q - sample_q;
	// |s - prev| <= sum / (steps - 1) with floor division is the same as
	// |s - prev| * (steps - 1) <= sum, since the deviation is whole
	assign dev_scaled = SUM_W'(dev) * SUM_W'(WINDOW_STEPS - 1);

	always_comb begin
		if (mode_q == MODE_RANGE) begin
			pass = (sample_q != '0) && (sample_q < ceiling_q);
		end else begin
			pass = (dev_scaled <= sum_q) && (sample_q > floor_q);
		end
	end

	assign sts.mode  = mode_q;
	assign sts.ready = ready;
	assign sts.emit  = (mode_q == MODE_ADAPTIVE) || (sample_q > floor_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RST;
			ceiling_q  <= CEILING_RST;
			floor_q    <= FLOOR_RST;
			wr_q       <= '0;
			fill_q     <= '0;
			held_q     <= '0;
			rd_vld_q   <= 1'b0;
			rd_first_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_MODE:    mode_q    <= cfg_data[0];
					REG_CEILING: ceiling_q <= cfg_data;
					REG_FLOOR:   floor_q   <= cfg_data;
					default:     ;
				endcase
			end
			if (cmd.accept && mode_q == MODE_ADAPTIVE) begin
				wr_q <= (wr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_q + AW'(1);
				if (!ready) begin
					fill_q <= fill_q + FW'(1);
				end
			end
			if (cmd.load_out && pass) begin
				held_q <= sample_q;
			end
			rd_vld_q   <= cmd.rd_issue;
			rd_first_q <= cmd.rd_first;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q  <= sample;
			rd_addr_q <= ring_back(wr_q);
		end else if (cmd.rd_issue) begin
			rd_addr_q <= ring_back(rd_addr_q);
		end
		// walk from the previous sample towards older entries
		if (rd_vld_q) begin
			last_q <= rdata;
			if (rd_first_q) begin
				prev_q <= rdata;
				sum_q  <= '0;
			end else begin
				sum_q <= sum_q + SUM_W'(step_diff);
			end
		end
		if (cmd.load_out) begin
			filtered_value <= pass ? sample_q : held_q;
			accepted       <= pass;
		end
	end

endmodule

// ===== design/aorf_ctrl.sv =====
module aorf_ctrl
	import aorf_pkg::*;
#(
	parameter int WINDOW_STEPS = WINDOW_STEPS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam int SW = $clog2(WINDOW_STEPS + 1);

	typedef enum logic [1:0] {
		IDLE,
		WALK,
		DRAIN,
		FINISH
	} state_t;

	state_t        state_q;
	logic [SW-1:0] step_q;
	logic          out_valid_q;
	logic          slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.accept   = (state_q == IDLE) && in_valid;
		cmd.rd_issue = (state_q == WALK);
		cmd.rd_first = (state_q == WALK) && (step_q == '0);
		cmd.load_out = (state_q == FINISH) && sts.emit && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					step_q <= '0;
					if (cmd.accept) begin
						if (sts.mode == MODE_RANGE) begin
							state_q <= FINISH;
						end else if (sts.ready) begin
							state_q <= WALK;
						end
					end
				end
				WALK: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(WINDOW_STEPS)) begin
						state_q <= DRAIN;
					end
				end
				// last read data lands in the sum
				DRAIN: state_q <= FINISH;
				FINISH: begin
					if (!sts.emit || slot_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && out_stall))
		else $error("result loaded over a waiting beat");

	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.mode == MODE_ADAPTIVE && sts.ready)
		|=> (state_q == WALK && step_q == '0))
		else $error("history walk did not start");

	a_drain_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DRAIN) |-> ($past(state_q) == WALK && $past(step_q) == SW'(WINDOW_STEPS)))
		else $error("walk ended early");

	a_warmup_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.mode == MODE_ADAPTIVE && !sts.ready) |=> (state_q == IDLE))
		else $error("warm-up sample left idle");

endmodule

// ===== bench/tb_adaptive_outlier_reject_filter.sv =====
`timescale 1ns / 1ps

module tb_adaptive_outlier_reject_filter;
	import aorf_pkg::*;

	localparam int HIST_DEPTH = HISTORY_DEPTH_DEF;
	localparam int WIN_STEPS  = WINDOW_STEPS_DEF;
	localparam int SETTLE_CYC = 40;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                acc;
	} filt_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
	logic [SAMPLE_W-1:0]  cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [SAMPLE_W-1:0]  sample = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [SAMPLE_W-1:0]  filtered_value;
	logic                 accepted;

	adaptive_outlier_reject_filter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.filtered_value(filtered_value),
		.accepted      (accepted)
	);

	always #2 clk = ~clk;

	// filter state as the predictor sees it
	logic                cur_mode = MODE_RST;
	logic [SAMPLE_W-1:0] ceil_r   = CEILING_RST;
	logic [SAMPLE_W-1:0] floor_r  = FLOOR_RST;
	logic [SAMPLE_W-1:0] hist [HIST_DEPTH];
	logic [3:0]          wr_ptr   = '0;
	int                  seen     = 0;
	logic [SAMPLE_W-1:0] held     = '0;

	filt_out_t due_results[$];
	int        errors   = 0;
	bit        gaps_on  = 1'b1;
	int        hold_req = 0;
	int        hold_left = 0;
	int        walk_level = 1000;

	task automatic filter_sample(input logic [SAMPLE_W-1:0] s);
		filt_out_t r;
		logic [3:0] cur, j, older;
		int sum, tol, prev, d;
		if (cur_mode == MODE_RANGE) begin
			if (s <= floor_r)
				return;
			if (s > 0 && s < ceil_r) begin
				held = s;
				r.value = s;
				r.acc = 1'b1;
			end else begin
				r.value = held;
				r.acc = 1'b0;
			end
			due_results.push_back(r);
			return;
		end
		cur = wr_ptr;
		hist[cur] = s;
		wr_ptr = cur + 4'd1;
		if (seen >= WIN_STEPS + 1) begin
			j = cur - 4'd1;
			prev = int'(hist[j]);
			sum = 0;
			for (int k = 0; k < WIN_STEPS; k++) begin
				older = j - 4'd1;
				d = int'(hist[j]) - int'(hist[older]);
				sum += (d < 0) ? -d : d;
				j = older;
			end
			tol = sum / (WIN_STEPS - 1);
			if (int'(s) >= prev - tol && int'(s) <= prev + tol && s > floor_r) begin
				held = s;
				r.value = s;
				r.acc = 1'b1;
			end else begin
				r.value = held;
				r.acc = 1'b0;
			end
			due_results.push_back(r);
		end
		if (seen < WIN_STEPS + 1)
			seen++;
	endtask

	// input beats feed the predictor, output beats are checked against it
	always @(posedge clk) begin
		filt_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: value=%0d accepted=%0b",
						filtered_value, accepted);
			end else begin
				want = due_results.pop_front();
				if (filtered_value !== want.value || accepted !== want.acc) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: value exp %0d got %0d, accepted exp %0b got %0b",
							want.value, filtered_value, want.acc, accepted);
				end
			end
		end
		if (arst_n && in_valid && !in_stall)
			filter_sample(sample);
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (gaps_on) begin
			out_stall <= ($urandom_range(0, 99) < 20);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		if (gaps_on && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (due_results.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_MODE)
			cur_mode = val[0];
		else if (idx == REG_CEILING)
			ceil_r = val;
		else if (idx == REG_FLOOR)
			floor_r = val;
	endtask

	task automatic set_filter(input logic m, input logic [SAMPLE_W-1:0] c,
			input logic [SAMPLE_W-1:0] f);
		drain();
		write_reg(REG_MODE, {{(SAMPLE_W-1){1'b0}}, m});
		write_reg(REG_CEILING, c);
		write_reg(REG_FLOOR, f);
	endtask

	function automatic logic [SAMPLE_W-1:0] next_sample(int amp);
		int r, v;
		r = int'($urandom_range(0, 99));
		if (cur_mode == MODE_RANGE) begin
			if (r < 30)
				v = int'($urandom_range(0, 65535));
			else if (r < 55)
				v = int'(floor_r) + int'($urandom_range(0, 8)) - 4;
			else if (r < 80)
				v = int'(ceil_r) + int'($urandom_range(0, 8)) - 4;
			else
				v = int'($urandom_range(0, ceil_r));
		end else begin
			if (r < 75) begin
				walk_level = walk_level + int'($urandom_range(0, 2 * amp)) - amp;
				if (walk_level < 0)
					walk_level = 0;
				if (walk_level > 65535)
					walk_level = 65535;
				v = walk_level;
			end else if (r < 88) begin
				// outlier spike either way
				v = int'($urandom_range(amp + 1, 4 * amp + 200));
				v = $urandom_range(0, 1) ? walk_level + v : walk_level - v;
			end else if (r < 96) begin
				v = int'($urandom_range(0, 65535));
			end else begin
				v = walk_level;
			end
		end
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic test_adaptive_warmup();
		// alternating extremes fill the ring, then a very wide window
		for (int i = 0; i < WIN_STEPS + 1; i++)
			send_sample((i % 2) ? 16'hFFFF : 16'h0000);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'd61);
		send_sample(16'd60);
		drain();
	endtask

	task automatic test_range_gate();
		set_filter(MODE_RANGE, 16'd5000, 16'd60);
		send_sample(16'd0);
		send_sample(16'd60);
		send_sample(16'd61);
		send_sample(16'd4999);
		send_sample(16'd5000);
		send_sample(16'hFFFF);
		set_filter(MODE_RANGE, 16'hFFFF, 16'h0000);
		send_sample(16'd0);
		send_sample(16'd1);
		send_sample(16'hFFFF);
		send_sample(16'hFFFE);
		set_filter(MODE_RANGE, 16'h0000, 16'h0000);
		send_sample(16'd7);
		drain();
	endtask

	task automatic test_random_phases();
		int n, amp;
		logic m;
		logic [SAMPLE_W-1:0] c, f;
		for (int p = 0; p < 10; p++) begin
			n = 80;
			case (p)
				0: begin m = MODE_RANGE;    c = 16'hFFFF; f = 16'h0000; end
				1: begin m = MODE_ADAPTIVE; c = 16'h0000; f = 16'h0000; end
				2: begin m = MODE_RANGE;    c = 16'h0000; f = 16'hFFFF; n = 15; end
				3: begin
					m = MODE_ADAPTIVE;
					c = 16'($urandom_range(0, 65535));
					f = 16'hFFFF;
				end
				default: begin
					m = 1'($urandom_range(0, 1));
					c = 16'($urandom_range(0, 65535));
					f = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(0, 300));
				end
			endcase
			set_filter(m, c, f);
			case ($urandom_range(0, 4))
				0: amp = 0;
				1: amp = 4;
				2: amp = 60;
				3: amp = 1500;
				default: amp = 20000;
			endcase
			walk_level = int'($urandom_range(0, 65535));
			for (int i = 0; i < n; i++)
				send_sample(next_sample(amp));
		end
		drain();
	endtask

	task automatic test_no_idle();
		set_filter(MODE_ADAPTIVE, CEILING_RST, FLOOR_RST);
		gaps_on = 1'b0;
		walk_level = 2000;
		for (int i = 0; i < 150; i++)
			send_sample(next_sample(40));
		drain();
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		set_filter(MODE_RANGE, 16'd40000, 16'd100);
		gaps_on = 1'b0;
		hold_req = 400;
		for (int i = 0; i < 40; i++)
			send_sample(next_sample(0));
		drain();
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_adaptive_warmup();
		test_range_gate();
		test_random_phases();
		test_no_idle();
		test_backpressure();
		drain();
		if (errors == 0 && due_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
